>>> design/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types and constants for the count code compress/expand unit.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam int REAL_W    = 32;  // real_count field width
  localparam int CODE_W    = 7;   // count code width
  localparam int EST_W     = 13;  // expanded count width
  localparam int DIV_STEPS = 8;   // quotient bits produced by the divider

  localparam logic OP_COMPRESS = 1'b0;
  localparam logic OP_EXPAND   = 1'b1;

  localparam logic [CODE_W-1:0] CODE_DISABLED = 7'd127;
  localparam logic [CODE_W-1:0] CODE_SAT      = 7'd126;
  localparam int                PASS_MAX      = 4;

  localparam logic signed [EST_W-1:0] EST_DISABLED = -13'sd1;

  // top -> core
  typedef struct packed {
    logic start;
    logic take;
  } fcce_ctrl_t;

  // core -> top
  typedef struct packed {
    logic idle;
    logic done;
  } fcce_stat_t;

endpackage

>>> design/fcce_if.sv
// ----------------------------------------------------------------------------
// fcce_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fcce_in_if
  import fcce_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [REAL_W-1:0] real_count;
  logic        [CODE_W-1:0] count_code;

  modport source (output valid, operation, real_count, count_code, input ready);
  modport sink   (input valid, operation, real_count, count_code, output ready);
endinterface

interface fcce_out_if
  import fcce_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic       [CODE_W-1:0] code_out;
  logic signed [EST_W-1:0] count_out;

  modport source (output valid, code_out, count_out, input ready);
  modport sink   (input valid, code_out, count_out, output ready);
endinterface

>>> design/fcce_sub.sv
// ----------------------------------------------------------------------------
// fcce_sub
// Shared compare/subtract unit used by the square root and divide steps.
// ----------------------------------------------------------------------------
module fcce_sub #(
  parameter int WIDTH = 19
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];

endmodule

>>> design/fcce_core.sv
// ----------------------------------------------------------------------------
// fcce_core
// Sequencer: digit-by-digit square root, then a short restoring divide,
// both through one shared subtractor. Expand mode resolves at start.
// ----------------------------------------------------------------------------
module fcce_core
  import fcce_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fcce_ctrl_t               ctrl,
  input  logic                     operation,
  input  logic signed [REAL_W-1:0] real_count,
  input  logic        [CODE_W-1:0] count_code,
  output fcce_stat_t               stat,
  output logic        [CODE_W-1:0] code_res,
  output logic signed  [EST_W-1:0] count_res
);

  localparam int VW    = (COUNT_WIDTH < REAL_W) ? COUNT_WIDTH : REAL_W;
  localparam int RADW  = ((VW + 2) / 2) * 2;          // radicand 2v+1, even width
  localparam int NR    = RADW / 2;                    // root bits
  localparam int SW    = NR + 2;                      // shared unit width
  localparam int CMAX  = (NR > DIV_STEPS) ? NR : DIV_STEPS;
  localparam int CW    = $clog2(CMAX);
  localparam int QW    = DIV_STEPS;

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_CSEL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           cnt_r;
  logic [VW-1:0]           v_r;
  logic [RADW-1:0]         rad_r;
  logic [SW-1:0]           rem_r;
  logic [NR-1:0]           root_r;
  logic [CODE_W-1:0]       c_r;
  logic [QW-1:0]           qsh_r;
  logic [CODE_W-1:0]       code_r;
  logic signed [EST_W-1:0] count_r;

  // input decode
  logic [VW-1:0]     v_in;
  logic [4:0]        y;
  logic [CODE_W-1:0] fac;
  logic [EST_W-1:0]  prod;
  logic [EST_W-1:0]  est;

  assign v_in = real_count[VW-1:0];
  assign y    = count_code[6:2];
  assign fac  = count_code - {1'b0, y, 1'b0};
  assign prod = EST_W'(fac) * EST_W'({1'b0, y} + 6'd1);
  assign est  = prod + EST_W'(y[4:1]);

  // shared unit operand select
  logic [SW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_ge;
  logic [SW-1:0] sq_sh;
  logic [QW-1:0] dv_sh;

  assign sq_sh = {rem_r[SW-3:0], rad_r[RADW-1 -: 2]};
  assign dv_sh = {rem_r[QW-2:0], qsh_r[QW-1]};

  always_comb begin
    if (state_r == S_DIV) begin
      alu_a = SW'(dv_sh);
      alu_b = SW'(c_r);
    end else begin
      alu_a = sq_sh;
      alu_b = {root_r, 2'b01};
    end
  end

  fcce_sub #(.WIDTH(SW)) u_sub (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  // divider setup and final sum
  logic [VW:0]       dbl;
  logic [VW:0]       dbl_hi;
  logic [CODE_W-1:0] s_inc;
  logic [8:0]        sum;

  assign dbl    = {v_r, 1'b0};
  assign dbl_hi = dbl >> QW;
  assign s_inc  = root_r[CODE_W-1:0] + 7'd1;
  assign sum    = 9'(c_r) + 9'(qsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ctrl.start) begin
            v_r    <= v_in;
            rad_r  <= RADW'({v_in, 1'b1});
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= CW'(NR - 1);
            if (operation == OP_EXPAND) begin
              code_r <= '0;
              if (count_code == CODE_DISABLED) begin
                count_r <= EST_DISABLED;
              end else if (count_code <= CODE_W'(PASS_MAX)) begin
                count_r <= EST_W'(count_code);
              end else begin
                count_r <= est;
              end
              state_r <= S_DONE;
            end else begin
              count_r <= '0;
              if (&v_in) begin
                code_r  <= CODE_DISABLED;
                state_r <= S_DONE;
              end else if (v_in[VW-1]) begin
                code_r  <= '0;
                state_r <= S_DONE;
              end else if (v_in <= VW'(PASS_MAX)) begin
                code_r  <= CODE_W'(v_in[2:0]);
                state_r <= S_DONE;
              end else begin
                state_r <= S_SQRT;
              end
            end
          end
        end
        S_SQRT: begin
          rad_r <= rad_r << 2;
          if (alu_ge) begin
            rem_r  <= alu_diff;
            root_r <= {root_r[NR-2:0], 1'b1};
          end else begin
            rem_r  <= sq_sh;
            root_r <= {root_r[NR-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_CSEL;
          end
        end
        S_CSEL: begin
          // root of 127 or more makes c at least 128: code saturates
          if (root_r >= NR'(CODE_DISABLED)) begin
            code_r  <= CODE_SAT;
            state_r <= S_DONE;
          end else begin
            // quotient stays below 2^8, so the high part is below c
            c_r     <= {s_inc[CODE_W-1:1], 1'b0};
            rem_r   <= SW'(dbl_hi[CODE_W-1:0]);
            qsh_r   <= dbl[QW-1:0];
            cnt_r   <= CW'(QW - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_ge) begin
            rem_r <= alu_diff;
          end else begin
            rem_r <= SW'(dv_sh);
          end
          qsh_r <= {qsh_r[QW-2:0], alu_ge};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (sum >= 9'd128) begin
            code_r <= CODE_SAT;
          end else begin
            code_r <= CODE_W'(sum - 9'd2);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (ctrl.take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign code_res  = code_r;
  assign count_res = count_r;

endmodule

>>> design/frequency_code_compress_expand_unit.sv
// ----------------------------------------------------------------------------
// frequency_code_compress_expand_unit
// Converts usage counts to 7-bit count codes and codes back to counts.
// ----------------------------------------------------------------------------
// Expand and short compress cases resolve as the input is taken; a root of 127
// or more runs the root steps and a check; other compress adds the divide steps
// and a final sum. Root bits NR = ceil((min(COUNT_WIDTH,32)+1)/2), 17 at 32.
// Throughput: one item at a time, the next input taken once the result moves
// to the output register; one root bit, then one of eight quotient bits a cycle.
// Reset: synchronous active-low rst_n returns to idle with no result pending.
module frequency_code_compress_expand_unit
  import fcce_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  fcce_in_if.sink     in_chan,
  fcce_out_if.source  out_chan
);

  fcce_ctrl_t              ctrl;
  fcce_stat_t              stat;
  logic       [CODE_W-1:0] code_res;
  logic signed [EST_W-1:0] count_res;

  logic                    out_valid_r;
  logic       [CODE_W-1:0] out_code_r;
  logic signed [EST_W-1:0] out_count_r;

  assign in_chan.ready = stat.idle;
  assign ctrl.start    = in_chan.valid & stat.idle;
  // result moves on when the output register is empty or drains this cycle
  assign ctrl.take     = stat.done & (~out_valid_r | out_chan.ready);

  fcce_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .operation  (in_chan.operation),
    .real_count (in_chan.real_count),
    .count_code (in_chan.count_code),
    .stat       (stat),
    .code_res   (code_res),
    .count_res  (count_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.take) begin
      out_valid_r <= 1'b1;
      out_code_r  <= code_res;
      out_count_r <= count_res;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.code_out  = out_code_r;
  assign out_chan.count_out = out_count_r;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the count code compress/expand unit. Drives
// compress and expand items over the input channel with random gaps and
// output stalls, predicts every result in the bench and compares each
// output transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb
  import fcce_pkg::*;
();

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles without any transfer
  localparam int TAIL_CYCLES = 60;    // beyond the longest compress latency

  typedef struct packed {
    logic                     operation;
    logic signed [REAL_W-1:0] real_count;
    logic        [CODE_W-1:0] count_code;
  } count_item_t;

  typedef struct packed {
    logic        [CODE_W-1:0] code;
    logic signed [EST_W-1:0]  estimate;
  } conversion_t;

  logic clk;
  logic rst_n;
  logic steady;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;
  int   errors;
  int   compress_cnt;
  int   expand_cnt;
  int   saturated_cnt;
  int   disabled_cnt;

  conversion_t expected_conversions[$];
  conversion_t want;

  fcce_in_if  in_if();
  fcce_out_if out_if();

  frequency_code_compress_expand_unit #(
    .COUNT_WIDTH(REAL_W)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      trial = r | (64'd1 << k);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] compress_count(input logic signed [REAL_W-1:0] cnt);
    logic [63:0] dbl;
    logic [63:0] c;
    if (cnt == -32'sd1) return CODE_DISABLED;
    if (cnt < 0) return '0;          // other negatives count as zero
    if (cnt <= PASS_MAX) return cnt[CODE_W-1:0];
    dbl = {32'd0, cnt} << 1;
    c = (floor_root(dbl + 64'd1) + 64'd1) & ~64'd1;
    c = c + dbl / c - 64'd2;
    return (c < CODE_SAT) ? c[CODE_W-1:0] : CODE_SAT;
  endfunction

  function automatic logic signed [EST_W-1:0] expand_code(input logic [CODE_W-1:0] code);
    int b;
    int y;
    if (code == CODE_DISABLED) return EST_DISABLED;
    if (code <= PASS_MAX) return EST_W'(code);
    b = code;
    y = b / 4;
    return EST_W'((b - 2 * y) * (y + 1) + y / 2);
  endfunction

  function automatic conversion_t convert_item(input count_item_t item);
    conversion_t res;
    if (item.operation == OP_COMPRESS) begin
      res.code     = compress_count(item.real_count);
      res.estimate = '0;
    end else begin
      res.code     = '0;
      res.estimate = expand_code(item.count_code);
    end
    return res;
  endfunction

  // ------------------------------------------------------------ random items
  function automatic logic signed [REAL_W-1:0] rand_count();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(63);
      3, 4:    return $urandom_range(4095);     // spans the saturation point
      5:       return $urandom;                 // full range, negatives too
      6:       return -$signed(REAL_W'($urandom_range(3)));
      7:       return $urandom >> $urandom_range(31);
      default: return $urandom_range(PASS_MAX + 1);
    endcase
  endfunction

  function automatic count_item_t rand_item();
    count_item_t item;
    item.operation  = 1'($urandom_range(1));
    item.real_count = rand_count();
    item.count_code = CODE_W'($urandom_range(127));
    return item;
  endfunction

  // ------------------------------------------------------------------ sender
  // Returns at the edge of the transfer with valid still high; callers that
  // do not send again in that step must lower it themselves.
  task automatic send_item(input count_item_t item);
    conversion_t res;
    if (!steady && $urandom_range(99) < 5) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(50, 1)) @(posedge clk);
    end
    while (!steady && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= item.operation;
    in_if.real_count <= item.real_count;
    in_if.count_code <= item.count_code;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = convert_item(item);
    expected_conversions.push_back(res);
    if (item.operation == OP_COMPRESS) compress_cnt++;
    else expand_cnt++;
    if (item.operation == OP_COMPRESS && res.code == CODE_SAT) saturated_cnt++;
    if (res.code == CODE_DISABLED || res.estimate == EST_DISABLED) disabled_cnt++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= (hold_left == 1);
    end else if (steady) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 16);
    end
  end

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_conversions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result code=%0d count=%0d",
                 $time, out_if.code_out, out_if.count_out);
      end else begin
        want = expected_conversions.pop_front();
        if (out_if.code_out !== want.code || out_if.count_out !== want.estimate) begin
          errors++;
          $display("%0t: mismatch code exp=%0d act=%0d, count exp=%0d act=%0d",
                   $time, want.code, out_if.code_out, want.estimate, out_if.count_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------- tests
  task automatic test_compress_corners();
    logic signed [REAL_W-1:0] corner_counts [13] = '{
      -32'sd1, -32'sd2, 32'sh8000_0000, 32'sd0, 32'sd1, 32'sd2, 32'sd3,
      32'sd4, 32'sd5, 32'sd100, 32'sd2047, 32'sd2048, 32'sh7fff_ffff};
    foreach (corner_counts[i])
      send_item(count_item_t'{OP_COMPRESS, corner_counts[i],
                              CODE_W'($urandom_range(127))});
  endtask

  task automatic test_expand_corners();
    logic [CODE_W-1:0] corner_codes [11] = '{
      7'd0, 7'd1, 7'd4, 7'd5, 7'd6, 7'd8, 7'd63, 7'd64, 7'd125, 7'd126, 7'd127};
    foreach (corner_codes[i])
      send_item(count_item_t'{OP_EXPAND, REAL_W'($urandom), corner_codes[i]});
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_item(rand_item());
  endtask

  // Output held off while the sender keeps offering, so the unit backs up.
  task automatic test_output_holdoff();
    hold_req <= hold_req + 1;
    repeat (20) send_item(rand_item());
  endtask

  task automatic test_drain_pause();
    repeat (15) send_item(rand_item());
    wait_drained();
    repeat (15) send_item(rand_item());
  endtask

  task automatic test_steady_stream();
    steady <= 1'b1;
    repeat (150) send_item(rand_item());
    steady <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    steady           = 1'b0;
    hold_req         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    quiet_cycles     = 0;
    errors           = 0;
    compress_cnt     = 0;
    expand_cnt       = 0;
    saturated_cnt    = 0;
    disabled_cnt     = 0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_COMPRESS;
    in_if.real_count = '0;
    in_if.count_code = '0;
    out_if.ready     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_compress_corners();
    test_expand_corners();
    test_random_mix(200);
    test_output_holdoff();
    test_drain_pause();
    test_steady_stream();
    test_random_mix(230);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d compress and %0d expand transfers (%0d saturated, %0d disabled).",
             compress_cnt, expand_cnt, saturated_cnt, disabled_cnt);
    $display("Included a %0d-cycle output hold-off, a drain pause and a gap-free stream.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
